### hw/rtl/cc20_pkg.sv
// Shared types, constants and helpers for the ChaCha20 keystream generator.
// Used by the register file, the quarter-round datapath and the top level.
// No dependencies.
`default_nettype none

package cc20_pkg;

    // Word and state geometry.
    localparam int WORD_W = 32;
    localparam int ROWS   = 4;
    localparam int COLS   = 4;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int WORDS  = ROWS * COLS;
    localparam int IDX_W  = $clog2(WORDS);

    // Round schedule: each double round is a column round and a diagonal round.
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(ROUNDS);

    // Configuration register file.
    localparam int CFG_COUNT   = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = $clog2(CFG_COUNT);
    localparam int CFG_IDX_LSB = 3;
    localparam int PADDR_W     = CFG_IDX_W + CFG_IDX_LSB;
    localparam int CTR_W       = 64;

    localparam logic [CFG_W-1:0] CONST_LO_RESET = 64'h3320_646E_6170_7865;
    localparam logic [CFG_W-1:0] CONST_HI_RESET = 64'h6B20_6574_7962_2D32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CONST_LO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_HI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE         = 3'd7;

    typedef logic [WORD_W-1:0] t_word;

    // One quarter-round operand set; element r lives in state memory r.
    typedef logic [ROWS-1:0][WORD_W-1:0] t_quad;

    typedef logic [CFG_COUNT-1:0][CFG_W-1:0] t_cfg_regs;

    // Register file contents after reset: sigma constants in the two lowest
    // registers, everything else zero.
    localparam t_cfg_regs CFG_RESET = {{((CFG_COUNT - 2) * CFG_W){1'b0}},
                                       CONST_HI_RESET, CONST_LO_RESET};

    // Control travelling alongside a quarter round towards write-back.
    typedef struct packed {
        logic                       valid;
        logic [ROWS-1:0][COL_W-1:0] addr;
    } t_qr_tag;

    // One result word with its position in the block.
    typedef struct packed {
        t_word            word;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_res;

    // Rotate a word left by a constant amount.
    function automatic t_word f_rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cc20_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds one row of the ChaCha20 working state. No dependencies.
`default_nettype none

module cc20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/cc20_regs.sv
// APB-style configuration registers: constants, key, start counter and nonce.
// Depends on cc20_pkg.
`default_nettype none

module cc20_regs
    import cc20_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready,
    output t_cfg_regs          o_regs
);

    t_cfg_regs            r_regs;
    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[PADDR_W-1:CFG_IDX_LSB];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes; the sigma constants come out of reset preloaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (w_wr) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    // Read-back.
    assign prdata = r_regs[w_idx];
    assign o_regs = r_regs;

endmodule

`default_nettype wire

### hw/rtl/cc20_qr.sv
// Two-stage quarter-round datapath: first half registered, second half
// combinational into the state memory write ports. Depends on cc20_pkg.
`default_nettype none

module cc20_qr
    import cc20_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_quad   i_words,
    input  t_qr_tag i_tag,
    output t_quad   o_words,
    output t_qr_tag o_tag
);

    t_quad   r_words;
    t_qr_tag r_tag;
    t_quad   w_half1;

    // First half: a += b, d = (d ^ a) <<< 16, c += d, b = (b ^ c) <<< 12.
    always_comb begin
        t_word a1;
        t_word b1;
        t_word c1;
        t_word d1;
        a1 = i_words[0] + i_words[1];
        d1 = f_rotl(i_words[3] ^ a1, 16);
        c1 = i_words[2] + d1;
        b1 = f_rotl(i_words[1] ^ c1, 12);
        w_half1[0] = a1;
        w_half1[1] = b1;
        w_half1[2] = c1;
        w_half1[3] = d1;
    end

    // Stage register between the two halves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
        r_tag.addr <= i_tag.addr;
        r_words    <= w_half1;
    end

    // Second half: a += b, d = (d ^ a) <<< 8, c += d, b = (b ^ c) <<< 7.
    always_comb begin
        t_word a2;
        t_word b2;
        t_word c2;
        t_word d2;
        a2 = r_words[0] + r_words[1];
        d2 = f_rotl(r_words[3] ^ a2, 8);
        c2 = r_words[2] + d2;
        b2 = f_rotl(r_words[1] ^ c2, 7);
        o_words[0] = a2;
        o_words[1] = b2;
        o_words[2] = c2;
        o_words[3] = d2;
    end

    assign o_tag = r_tag;

endmodule

`default_nettype wire

### hw/rtl/chacha20_block_keystream.sv
// ChaCha20 keystream generator, 64-bit counter and 64-bit nonce layout.
// Block rate is set by the round loop through the four row memories: one
// quarter round issued per cycle, with a drain state for write-back before
// the next round may read. A new request is taken only once the previous
// block has been read from the memories.
// Reset: synchronous, active low; sigma constants loaded, key, nonce and counter zero.
`default_nettype none

module chacha20_block_keystream
    import cc20_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready,
    // Request channel
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  logic               i_reload_counter,
    // Result channel
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output logic [WORD_W-1:0]  o_stream_word,
    output logic [IDX_W-1:0]   o_word_index,
    output logic               o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_DRAIN,
        S_OUT
    } t_state;

    t_cfg_regs w_regs;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [RND_W-1:0]   r_rnd, n_rnd;
    logic               r_drain, n_drain;
    logic [IDX_W-1:0]   r_widx, n_widx;
    logic               r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [CTR_W-1:0]   r_counter, n_counter;
    logic [CTR_W-1:0]   r_blk_ctr, n_blk_ctr;
    t_qr_tag            r_iss, n_iss;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;
    logic               r_skid_valid, n_skid_valid;
    t_res               r_skid, n_skid;

    logic                       w_accept;
    logic                       w_take;
    logic                       w_rd_issue;
    logic [1:0]                 w_occ;
    logic [ROWS-1:0][COL_W-1:0] w_raddr;
    t_quad                      w_rdata;
    t_quad                      w_qr_words;
    t_qr_tag                    w_qr_tag;
    t_res                       w_new;

    // Initial state word: constants, key and nonce from the registers, counter
    // words from the block's own counter.
    function automatic t_word f_init_word(input t_cfg_regs regs,
                                          input logic [CTR_W-1:0] ctr,
                                          input logic [IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        if (idx[IDX_W-1:1] == REG_START_COUNTER) begin
            v = ctr;
        end else begin
            v = regs[idx[IDX_W-1:1]];
        end
        return idx[0] ? v[CFG_W-1:WORD_W] : v[WORD_W-1:0];
    endfunction

    cc20_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_regs  (w_regs)
    );

    // Request handshake: a new block starts once the previous one has left
    // the memories.
    assign o_req_stall = !((r_state == S_IDLE) && !r_rd_pend);
    assign w_accept    = i_req_valid && !o_req_stall;

    // Output slots in use, counting a read still in flight.
    assign w_take     = r_out_valid && !i_res_stall;
    assign w_occ      = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, r_rd_pend};
    assign w_rd_issue = (r_state == S_OUT) && ((w_occ - {1'b0, w_take}) <= 2'd1);

    // Read addresses: column or diagonal pattern during rounds, one column
    // across all rows while unloading.
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            if (r_state == S_OUT) begin
                w_raddr[r] = r_widx[COL_W-1:0];
            end else if (r_rnd[0]) begin
                w_raddr[r] = r_col + COL_W'(r);
            end else begin
                w_raddr[r] = r_col;
            end
        end
    end

    // One memory per state row; the write side takes initial words or
    // finished quarter rounds.
    for (genvar g = 0; g < ROWS; g++) begin : g_row
        logic              w_we;
        logic [COL_W-1:0]  w_waddr;
        t_word             w_wdata;

        always_comb begin
            if (r_state == S_INIT) begin
                w_we    = 1'b1;
                w_waddr = r_col;
                w_wdata = f_init_word(w_regs, r_blk_ctr, {ROW_W'(g), r_col});
            end else begin
                w_we    = w_qr_tag.valid;
                w_waddr = w_qr_tag.addr[g];
                w_wdata = w_qr_words[g];
            end
        end

        cc20_ram #(
            .WIDTH (WORD_W),
            .DEPTH (COLS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    cc20_qr u_qr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_words (w_rdata),
        .i_tag   (r_iss),
        .o_words (w_qr_words),
        .o_tag   (w_qr_tag)
    );

    // Final addition of the starting state to the returning word.
    always_comb begin
        w_new.word = w_rdata[r_rd_idx[IDX_W-1:COL_W]]
                   + f_init_word(w_regs, r_blk_ctr, r_rd_idx);
        w_new.idx  = r_rd_idx;
        w_new.last = (r_rd_idx == IDX_W'(WORDS - 1));
    end

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_rnd     = r_rnd;
        n_drain   = r_drain;
        n_widx    = r_widx;
        n_counter = r_counter;
        n_blk_ctr = r_blk_ctr;
        n_iss     = '0;
        n_iss.addr = w_raddr;
        n_rd_pend = w_rd_issue;
        n_rd_idx  = r_rd_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_blk_ctr = i_reload_counter ? w_regs[REG_START_COUNTER] : r_counter;
                    n_counter = n_blk_ctr + CTR_W'(1);
                    n_col     = '0;
                    n_state   = S_INIT;
                end
            end
            S_INIT: begin
                n_col = r_col + COL_W'(1);
                if (r_col == COL_W'(COLS - 1)) begin
                    n_rnd   = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_iss.valid = 1'b1;
                n_col       = r_col + COL_W'(1);
                if (r_col == COL_W'(COLS - 1)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    if (r_rnd == RND_W'(ROUNDS - 1)) begin
                        n_widx  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_rnd   = r_rnd + RND_W'(1);
                        n_col   = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_OUT: begin
                if (w_rd_issue) begin
                    n_rd_idx = r_widx;
                    n_widx   = r_widx + IDX_W'(1);
                    if (r_widx == IDX_W'(WORDS - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register with skid stage.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (r_rd_pend) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_new;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_new;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_rnd        <= '0;
            r_drain      <= 1'b0;
            r_widx       <= '0;
            r_rd_pend    <= 1'b0;
            r_counter    <= '0;
            r_iss.valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_rnd        <= n_rnd;
            r_drain      <= n_drain;
            r_widx       <= n_widx;
            r_rd_pend    <= n_rd_pend;
            r_counter    <= n_counter;
            r_iss.valid  <= n_iss.valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_rd_idx   <= n_rd_idx;
        r_blk_ctr  <= n_blk_ctr;
        r_iss.addr <= n_iss.addr;
        r_out      <= n_out;
        r_skid     <= n_skid;
    end

    assign o_res_valid   = r_out_valid;
    assign o_stream_word = r_out.word;
    assign o_word_index  = r_out.idx;
    assign o_last_word   = r_out.last;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the ChaCha20 keystream generator.
// It predicts each block of sixteen words, drives requests and configuration writes,
// and checks every result word. It depends on cc20_pkg and chacha20_block_keystream.
`timescale 1ns / 100ps

module tb_top;
    import cc20_pkg::*;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_state;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int BUSY_PCT      = 77;
    localparam int BOTH_PCT      = 35;
    localparam int HOLD_CYCLES   = 700;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int RAND_PHASES   = 8;
    localparam int RAND_ITEMS    = 46;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;
    logic               req_valid;
    logic               req_stall;
    logic               req_reload;
    logic               res_valid;
    logic               res_stall;
    logic [WORD_W-1:0]  res_word;
    logic [IDX_W-1:0]   res_idx;
    logic               res_last;

    // Shadow copies of the register file and the running block counter.
    t_cfg_regs          cfg_shadow;
    logic [CTR_W-1:0]   run_ctr;

    logic               pending_reload[$];
    t_res               expected_words[$];
    t_idle_mode         idle_mode;
    bit                 hold_req;
    bit                 hold_taken;
    int                 hold_left;
    int                 err_cnt;
    int                 quiet_cycles;

    chacha20_block_keystream i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_req_valid      (req_valid),
        .o_req_stall      (req_stall),
        .i_reload_counter (req_reload),
        .o_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .o_stream_word    (res_word),
        .o_word_index     (res_idx),
        .o_last_word      (res_last)
    );

    // Clock generation.
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Rotate left, taken from a doubled copy of the word.
    function automatic t_word rol(input t_word v, input int n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v};
        return dbl[2*WORD_W-1-n -: WORD_W];
    endfunction

    // One add-rotate-xor quarter round on four words of the state.
    function automatic t_state quarter(input t_state s, input int a, input int b,
                                       input int c, input int d);
        s[a] = s[a] + s[b];
        s[d] = rol(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d];
        s[b] = rol(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b];
        s[d] = rol(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d];
        s[b] = rol(s[b] ^ s[c], 7);
        return s;
    endfunction

    // Full keystream block for the current registers and the given counter.
    function automatic t_state keystream_block(input logic [CTR_W-1:0] ctr);
        t_state seed;
        t_state ws;
        int     r;
        for (r = 0; r < 6; r++) begin
            seed[2*r]   = cfg_shadow[r][31:0];
            seed[2*r+1] = cfg_shadow[r][63:32];
        end
        seed[12] = ctr[31:0];
        seed[13] = ctr[63:32];
        seed[14] = cfg_shadow[REG_NONCE][31:0];
        seed[15] = cfg_shadow[REG_NONCE][63:32];
        ws = seed;
        for (r = 0; r < DOUBLE_ROUNDS; r++) begin
            ws = quarter(ws, 0, 4, 8, 12);
            ws = quarter(ws, 1, 5, 9, 13);
            ws = quarter(ws, 2, 6, 10, 14);
            ws = quarter(ws, 3, 7, 11, 15);
            ws = quarter(ws, 0, 5, 10, 15);
            ws = quarter(ws, 1, 6, 11, 12);
            ws = quarter(ws, 2, 7, 8, 13);
            ws = quarter(ws, 3, 4, 9, 14);
        end
        for (r = 0; r < WORDS; r++) begin
            ws[r] = ws[r] + seed[r];
        end
        return ws;
    endfunction

    // Random draw: is this side busy doing nothing in the coming cycle?
    function automatic bit side_idle(input bit sender);
        int pct;
        pct = 0;
        if (idle_mode == IDLE_BOTH)
            pct = BOTH_PCT;
        else if ((sender && idle_mode == IDLE_SEND) || (!sender && idle_mode == IDLE_RECV))
            pct = BUSY_PCT;
        return $urandom_range(99) < pct;
    endfunction

    // Request driver: predicts a block on each accepted request, then offers the next.
    always @(posedge clk) begin : drv_proc
        t_state ks;
        t_res   exp_r;
        int     k;
        if (!rst_n) begin
            req_valid  <= 1'b0;
            req_reload <= 1'b0;
            run_ctr = '0;
        end else begin
            if (req_valid && !req_stall) begin
                if (req_reload)
                    run_ctr = cfg_shadow[REG_START_COUNTER];
                ks = keystream_block(run_ctr);
                for (k = 0; k < WORDS; k++) begin
                    exp_r.word = ks[k];
                    exp_r.idx  = IDX_W'(k);
                    exp_r.last = (k == WORDS - 1);
                    expected_words.push_back(exp_r);
                end
                run_ctr = run_ctr + 1'b1;
            end
            if (!req_valid || !req_stall) begin
                if (pending_reload.size() != 0 && !side_idle(1'b1)) begin
                    req_valid  <= 1'b1;
                    req_reload <= pending_reload.pop_front();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted word and draws the stall for the next cycle.
    always @(posedge clk) begin : mon_proc
        t_res exp_r;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %h at index %0d", res_word, res_idx);
                    err_cnt++;
                end else begin
                    exp_r = expected_words.pop_front();
                    if (res_word !== exp_r.word) begin
                        $error("stream_word: expected %h, got %h", exp_r.word, res_word);
                        err_cnt++;
                    end
                    if (res_idx !== exp_r.idx) begin
                        $error("word_index: expected %0d, got %0d", exp_r.idx, res_idx);
                        err_cnt++;
                    end
                    if (res_last !== exp_r.last) begin
                        $error("last_word: expected %0d, got %0d", exp_r.last, res_last);
                        err_cnt++;
                    end
                end
            end
            // A long hold-off lets the generator fill up and push back on requests.
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= side_idle(1'b0);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[chacha20_block_keystream] ERROR");
                $finish;
            end
        end
    end

    // Register write over the configuration port: setup cycle then access cycle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {CFG_IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow[idx] = val;
    endtask

    // Wait until every queued request has gone in and every word has come back.
    task automatic wait_idle();
        while (pending_reload.size() != 0 || req_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Sequence: reset, directed blocks, random phases under each idling pattern, then back-pressure.
    initial begin : seq_proc
        int               p;
        int               i;
        int               r;
        logic [CFG_W-1:0] v;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req_reload = 1'b0;
        res_stall = 1'b0;
        hold_req  = 1'b0;
        hold_taken = 1'b0;
        hold_left = 0;
        err_cnt   = 0;
        quiet_cycles = 0;
        idle_mode = IDLE_NONE;
        cfg_shadow = '0;
        cfg_shadow[REG_CONST_LO] = CONST_LO_RESET;
        cfg_shadow[REG_CONST_HI] = CONST_HI_RESET;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: running counter, then an explicit reload of zero.
        pending_reload = '{1'b0, 1'b0, 1'b1, 1'b0};
        wait_idle();

        // All ones in the constants, key and nonce; the counter wraps from its top value to zero.
        cfg_write(REG_CONST_LO, '1);
        cfg_write(REG_CONST_HI, '1);
        cfg_write(REG_KEY_A, '1);
        cfg_write(REG_KEY_B, '1);
        cfg_write(REG_KEY_C, '1);
        cfg_write(REG_KEY_D, '1);
        cfg_write(REG_NONCE, '1);
        cfg_write(REG_START_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE);
        pending_reload = '{1'b1, 1'b0, 1'b0, 1'b0};
        wait_idle();

        // All zeros but the counter; carry out of the low counter word.
        for (r = 0; r < CFG_COUNT; r++)
            cfg_write(CFG_IDX_W'(r), '0);
        cfg_write(REG_START_COUNTER, 64'h0000_0000_FFFF_FFFF);
        pending_reload = '{1'b1, 1'b0};
        wait_idle();

        // A new start value only matters once a request asks for a reload.
        cfg_write(REG_CONST_LO, CONST_LO_RESET);
        cfg_write(REG_CONST_HI, CONST_HI_RESET);
        cfg_write(REG_KEY_A, 64'h0706_0504_0302_0100);
        cfg_write(REG_START_COUNTER, 64'h8000_0000_0000_0000);
        pending_reload = '{1'b0, 1'b0, 1'b1, 1'b0};
        wait_idle();

        // Random phases, each idling pattern twice, with fresh register contents.
        for (p = 0; p < RAND_PHASES; p++) begin
            for (r = 0; r < CFG_COUNT; r++) begin
                if ($urandom_range(1) == 0) begin
                    case ($urandom_range(9))
                        0: v = '0;
                        1: v = '1;
                        default: v = {$urandom, $urandom};
                    endcase
                    cfg_write(CFG_IDX_W'(r), v);
                end
            end
            idle_mode = t_idle_mode'(p % 4);
            for (i = 0; i < RAND_ITEMS; i++)
                pending_reload.push_back($urandom_range(7) == 0);
            wait_idle();
        end

        // Back-pressure: the receiver holds off while requests keep coming.
        idle_mode = IDLE_NONE;
        hold_req  = 1'b1;
        for (i = 0; i < 24; i++)
            pending_reload.push_back($urandom_range(3) == 0);
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0 && expected_words.size() == 0) begin
            $display("[chacha20_block_keystream] OK");
        end else begin
            $display("[chacha20_block_keystream] ERROR");
        end
        $finish;
    end

endmodule
